### hdl/fnws_pkg.sv
// fnws_pkg: shared types, constants and the atan table for the waypoint search
// no dependencies
package fnws_pkg;
  localparam int MaxWaypoints = 1024;
  localparam int AddrW = $clog2(MaxWaypoints);
  localparam int CntW = $clog2(MaxWaypoints + 1);
  localparam int PosW = 24;
  localparam int DiffW = 25;
  localparam int CordW = 28;
  localparam int ZW = 20;
  localparam int RelW = 20;
  localparam int DistW = 50;
  localparam int HalfPiQ16 = 102944;
  localparam int PiQ13 = 25736;
  localparam int TwoPiQ13 = 51472;

  // configuration register indexes
  localparam int CfgHalfAngle = 0;
  localparam int CfgMinRange = 1;

  typedef enum logic [1:0] {
    REQ_POSE = 2'd0,
    REQ_LOAD = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SETUP, ST_ROT, ST_EVAL, ST_OUT
  } state_t;

  // input word: request code, position, heading
  typedef struct packed {
    req_t req_type;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [15:0] heading;
  } in_word_t;

  // result word: selected waypoint and hit flag
  typedef struct packed {
    logic signed [PosW-1:0] best_x;
    logic signed [PosW-1:0] best_y;
    logic found;
  } out_word_t;

  typedef struct packed {
    logic pose_ld;
    logic wp_wr;
    logic srch_clr;
    logic rd;
    logic setup;
    logic rot;
    logic eval;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic rot_last;
    logic full;
  } sts_t;

  function automatic logic [17:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0: atan_q16 = 18'd51472;
      4'd1: atan_q16 = 18'd30386;
      4'd2: atan_q16 = 18'd16055;
      4'd3: atan_q16 = 18'd8150;
      4'd4: atan_q16 = 18'd4091;
      4'd5: atan_q16 = 18'd2047;
      4'd6: atan_q16 = 18'd1024;
      4'd7: atan_q16 = 18'd512;
      4'd8: atan_q16 = 18'd256;
      4'd9: atan_q16 = 18'd128;
      4'd10: atan_q16 = 18'd64;
      4'd11: atan_q16 = 18'd32;
      4'd12: atan_q16 = 18'd16;
      4'd13: atan_q16 = 18'd8;
      4'd14: atan_q16 = 18'd4;
      default: atan_q16 = 18'd2;
    endcase
  endfunction
endpackage

### hdl/fnws_if.sv
// fnws_if: valid/ready channel carrying one word of a generic payload
// depends on nothing
interface fnws_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/fnws_ram.sv
// fnws_ram: generic single port ram with registered read
// depends on nothing
module fnws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];
  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    rdata <= mem_r[addr];
  end
endmodule

### hdl/fnws_ctrl.sv
// fnws_ctrl: request sequencer for the waypoint search
// depends on fnws_pkg
module fnws_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_req,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fnws_pkg::sts_t  sts,
  output fnws_pkg::cmd_t  cmd
);
  import fnws_pkg::*;
  state_t state_r, state_nxt;
  logic acc;
  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (acc && req_t'(in_req) == REQ_SEARCH)
        state_nxt = sts.more ? ST_READ : ST_OUT;
      ST_READ: state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_ROT;
      ST_ROT: if (sts.rot_last) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = sts.more ? ST_READ : ST_OUT;
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    cmd = '0;
    cmd.pose_ld = acc && req_t'(in_req) == REQ_POSE;
    cmd.wp_wr = acc && req_t'(in_req) == REQ_LOAD && !sts.full;
    cmd.srch_clr = acc && req_t'(in_req) == REQ_SEARCH;
    cmd.rd = (state_r == ST_READ);
    cmd.setup = (state_r == ST_SETUP);
    cmd.rot = (state_r == ST_ROT);
    cmd.eval = (state_r == ST_EVAL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
endmodule

### hdl/fnws_dp.sv
// fnws_dp: waypoint stores, pose, cordic bearing unit and best-candidate tracking
// depends on fnws_pkg and fnws_ram
module fnws_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fnws_pkg::cmd_t                cmd,
  output fnws_pkg::sts_t                sts,
  input  logic signed [fnws_pkg::PosW-1:0] in_x,
  input  logic signed [fnws_pkg::PosW-1:0] in_y,
  input  logic signed [15:0]            in_heading,
  input  logic [14:0]                   half_angle,
  input  logic [15:0]                   min_range,
  output logic signed [fnws_pkg::PosW-1:0] best_x,
  output logic signed [fnws_pkg::PosW-1:0] best_y,
  output logic                          found
);
  import fnws_pkg::*;
  logic [CntW-1:0] count_r, idx_r;
  logic [AddrW-1:0] addr;
  logic signed [PosW-1:0] vx_r, vy_r, wx, wy, wx_r, wy_r;
  logic signed [15:0] hd_r;
  logic signed [DiffW-1:0] dx_r, dy_r;
  logic signed [CordW-1:0] cx_r, cy_r, cxs, cys;
  logic signed [ZW-1:0] z_r, z_fin;
  logic [3:0] it_r;
  logic zero_r;
  logic [DistW-1:0] best_d_r, dxx_r, dyy_r, d2, min_sq;
  logic signed [RelW-1:0] bear, rel, rel_w;
  logic [RelW-1:0] mag;
  logic signed [PosW-1:0] bx_r, by_r;
  logic found_r, hit;

  assign addr = cmd.wp_wr ? count_r[AddrW-1:0] : idx_r[AddrW-1:0];

  fnws_ram #(.Width(PosW), .Depth(MaxWaypoints)) u_xram (
    .clk(clk), .we(cmd.wp_wr), .addr(addr), .wdata(in_x), .rdata(wx));
  fnws_ram #(.Width(PosW), .Depth(MaxWaypoints)) u_yram (
    .clk(clk), .we(cmd.wp_wr), .addr(addr), .wdata(in_y), .rdata(wy));

  assign sts.full = (count_r == CntW'(MaxWaypoints));
  assign sts.more = cmd.srch_clr ? (count_r != '0) : (idx_r != count_r);
  assign sts.rot_last = (it_r == 4'd15);

  assign cxs = cx_r >>> it_r;
  assign cys = cy_r >>> it_r;
  assign z_fin = (z_r + ZW'(4)) >>> 3;
  assign bear = zero_r ? '0 : RelW'(z_fin);
  assign rel = bear - RelW'(hd_r);
  // rel stays within +-3 pi, so one wrap step suffices
  always_comb begin
    rel_w = rel;
    if (rel > RelW'(PiQ13)) rel_w = rel - RelW'(TwoPiQ13);
    else if (rel < -RelW'(PiQ13)) rel_w = rel + RelW'(TwoPiQ13);
  end
  assign mag = rel_w[RelW-1] ? RelW'(-rel_w) : RelW'(rel_w);
  assign min_sq = DistW'(32'(min_range) * 32'(min_range));
  assign d2 = dxx_r + dyy_r;
  assign hit = (mag < RelW'(half_angle)) && (d2 < best_d_r) && (d2 > min_sq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      vx_r <= '0;
      vy_r <= '0;
      hd_r <= '0;
      best_d_r <= '1;
      found_r <= 1'b0;
    end else begin
      if (cmd.pose_ld) begin
        vx_r <= in_x;
        vy_r <= in_y;
        hd_r <= in_heading;
      end
      if (cmd.wp_wr) count_r <= count_r + 1'b1;
      if (cmd.srch_clr) begin
        best_d_r <= '1;
        found_r <= 1'b0;
      end else if (cmd.eval && hit) begin
        best_d_r <= d2;
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_clr) begin
      idx_r <= '0;
      bx_r <= '0;
      by_r <= '0;
    end
    if (cmd.rd) idx_r <= idx_r + 1'b1;
    if (cmd.setup) begin
      wx_r <= wx;
      wy_r <= wy;
      dx_r <= DiffW'(wx) - DiffW'(vx_r);
      dy_r <= DiffW'(wy) - DiffW'(vy_r);
      it_r <= '0;
    end
    if (cmd.rot) begin
      it_r <= it_r + 1'b1;
      if (it_r == 4'd0) begin
        // first iteration: square terms, quadrant pre-turn folded into step 0
        dxx_r <= DistW'(dx_r * dx_r);
        dyy_r <= DistW'(dy_r * dy_r);
        zero_r <= (dx_r == '0) && (dy_r == '0);
        if (dx_r[DiffW-1]) begin
          if (!dy_r[DiffW-1]) begin
            // turned to (dy, -dx), y is then positive
            cx_r <= CordW'(dy_r) - CordW'(dx_r);
            cy_r <= -CordW'(dx_r) - CordW'(dy_r);
            z_r <= ZW'(HalfPiQ16) + ZW'(atan_q16(4'd0));
          end else begin
            // turned to (-dy, dx), y is then negative
            cx_r <= -CordW'(dy_r) - CordW'(dx_r);
            cy_r <= CordW'(dx_r) - CordW'(dy_r);
            z_r <= -ZW'(HalfPiQ16) - ZW'(atan_q16(4'd0));
          end
        end else if (!dy_r[DiffW-1]) begin
          cx_r <= CordW'(dx_r) + CordW'(dy_r);
          cy_r <= CordW'(dy_r) - CordW'(dx_r);
          z_r <= ZW'(atan_q16(4'd0));
        end else begin
          cx_r <= CordW'(dx_r) - CordW'(dy_r);
          cy_r <= CordW'(dy_r) + CordW'(dx_r);
          z_r <= -ZW'(atan_q16(4'd0));
        end
      end else if (cys >= 0) begin
        cx_r <= cx_r + cys;
        cy_r <= cy_r - cxs;
        z_r <= z_r + ZW'(atan_q16(it_r));
      end else begin
        cx_r <= cx_r - cys;
        cy_r <= cy_r + cxs;
        z_r <= z_r - ZW'(atan_q16(it_r));
      end
    end
    if (cmd.eval && hit) begin
      bx_r <= wx_r;
      by_r <= wy_r;
    end
  end

  assign best_x = bx_r;
  assign best_y = by_r;
  assign found = found_r;
endmodule

### hdl/forward_nearest_waypoint_search_unit.sv
// forward_nearest_waypoint_search_unit: top level of the waypoint search
// depends on fnws_pkg, fnws_if, fnws_ctrl, fnws_dp, fnws_ram
//
// in channel: one word per request; req_type 0 sets the pose (x, y, heading),
// 1 appends a waypoint (dropped when the store is full), 2 runs a search,
// 3 is ignored. out channel: one word per search (best_x, best_y, found)
// cfg port: index 0 cone half angle, index 1 minimum distance
// pose and append words are taken while idle and leave the unit ready for the next word
// a search visits the stored waypoints in turn after its accepting edge; the
// result word is valid once the last one is evaluated (or directly when the store is
// empty), and the next word is accepted only after the result has been taken
// each waypoint needs a ram read, a setup step, 16 cordic iterations on the
// shared bearing unit and one compare step
// the result word stays in the output register until taken; no new word is
// accepted while a search runs or its result is held
// reset empties the store, zeroes the pose and restores register defaults;
// ram contents are not cleared, only entries below the count are read
module forward_nearest_waypoint_search_unit (
  input  logic clk,
  input  logic rst_n,
  fnws_if.sink   in_ch,
  fnws_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import fnws_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic [14:0] half_angle_r;
  logic [15:0] min_range_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_angle_r <= 15'd12288;
      min_range_r <= 16'd169;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CfgHalfAngle)) half_angle_r <= cfg_wdata[14:0];
      else if (cfg_index == 1'(CfgMinRange)) min_range_r <= cfg_wdata;
    end
  end

  fnws_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_req(in_ch.data.req_type), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd));

  fnws_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_x(in_ch.data.pos_x), .in_y(in_ch.data.pos_y),
    .in_heading(in_ch.data.heading),
    .half_angle(half_angle_r), .min_range(min_range_r),
    .best_x(out_ch.data.best_x), .best_y(out_ch.data.best_y),
    .found(out_ch.data.found));

  // never ready for input while a result word is valid
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("in ready during result hold");
  // result word holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
    else $error("result changed while stalled");
endmodule
